@@ src/nbgs_pkg.sv @@
// nbgs_pkg: shared constants, types and helpers for the gravity step block.
// No dependencies.
package nbgs_pkg;

    localparam int MAX_CENTRES = 5;
    localparam int IDX_W       = 3;
    localparam int FRAC_BITS   = 24;
    localparam int DT_BITS     = 24;
    localparam int PULL_SHIFT  = 3 * FRAC_BITS - 33;
    localparam int PIX_SHIFT   = FRAC_BITS + 8;
    localparam logic [63:0] MILLI_Q38 = 64'd274877907;
    localparam logic [32:0] PULL_CAP  = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        OP_STAR    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_LOAD    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_NUM_GALAXIES = 3'd0,
        CFG_TIME_STEP    = 3'd1,
        CFG_PIXEL_SCALE  = 3'd2,
        CFG_CENTER_X     = 3'd3,
        CFG_CENTER_Y     = 3'd4,
        CFG_CLIP_RIGHT   = 3'd5,
        CFG_CLIP_BOTTOM  = 3'd6
    } t_cfg;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        t_vec3       pos;
        t_vec3       vel;
        logic [9:0]  mass;
    } t_gal;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/nbgs_cell.sv @@
// nbgs_cell: one galaxy centre slot of the rotating centre ring.
// Depends on nbgs_pkg.
module nbgs_cell import nbgs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  t_gal i_shift_data,
    input  logic i_wr,
    input  t_gal i_wr_data,
    output t_gal o_data
);

    t_gal r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_wr) begin
            r_data <= i_wr_data;
        end else if (i_shift) begin
            r_data <= i_shift_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ src/nbgs_mul.sv @@
// nbgs_mul: 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on nbgs_pkg.
module nbgs_mul import nbgs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_p
);

    logic [63:0]  r_a, r_b, r_pp;
    logic [127:0] r_acc;
    logic [1:0]   r_sh;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic [31:0]  w_ap, w_bp;
    logic [63:0]  w_pp;

    assign w_ap = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_bp = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = {32'b0, w_ap} * {32'b0, w_bp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp <= w_pp;
                    r_sh <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + ({64'b0, r_pp} << {r_sh, 5'b0});
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

@@ src/nbgs_div.sv @@
// nbgs_div: restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
// Requires the upper dividend half below the divisor. Depends on nbgs_pkg.
module nbgs_div import nbgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_d,
    output logic        o_done,
    output logic [63:0] o_q
);

    logic [63:0] r_rem, r_lo, r_q, r_d;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_sh, w_sub;
    logic        w_ge;

    assign w_sh  = {r_rem, r_lo[63]};
    assign w_ge  = w_sh >= {1'b0, r_d};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_hi;
                r_lo   <= i_lo;
                r_d    <= i_d;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[63:0] : w_sh[63:0];
                r_lo  <= {r_lo[62:0], 1'b0};
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

@@ src/nbgs_isqrt.sv @@
// nbgs_isqrt: integer square root of a 64-bit value, one result bit per cycle.
// Depends on nbgs_pkg.
module nbgs_isqrt import nbgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_s,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_s, r_res, r_bit;
    logic        r_busy, r_done;
    logic [63:0] w_t;

    assign w_t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_s    <= i_s;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_s >= w_t) begin
                    r_s   <= r_s - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

@@ src/nbgs_pull.sv @@
// nbgs_pull: gravitational pull of one centre on one body, added to its velocity.
// Depends on nbgs_pkg, nbgs_mul, nbgs_div, nbgs_isqrt.
module nbgs_pull import nbgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_vec3       i_from,
    input  t_vec3       i_to,
    input  t_vec3       i_vel,
    input  logic [9:0]  i_mass,
    input  logic [23:0] i_dt,
    output logic        o_done,
    output t_vec3       o_vel
);

    typedef enum logic [4:0] {
        P_IDLE, P_SQ, P_SQW, P_SQRT, P_SQRTW, P_K1, P_K1W, P_K2, P_K2W,
        P_H2, P_H2W, P_PDIV, P_PDIVW, P_AX, P_AXMW, P_AXDW, P_FIN
    } t_pstate;

    t_pstate          r_state;
    t_vec3            r_vel;
    logic [2:0][32:0] r_a;
    logic [2:0]       r_neg;
    logic [9:0]       r_mass;
    logic [63:0]      r_s, r_k, r_h2, r_p;
    logic [31:0]      r_h;
    logic             r_pcap;
    logic [1:0]       r_ax;
    logic             r_done;

    logic             mul_start, mul_done;
    logic [63:0]      mul_a, mul_b;
    logic [127:0]     mul_p;
    logic             div_start, div_done;
    logic [63:0]      div_hi, div_lo, div_d, div_q;
    logic             sq_start, sq_done;
    logic [31:0]      sq_root;

    logic signed [32:0] w_d [3];
    logic [63:0]        w_khi, w_klo;
    logic [32:0]        w_m;
    logic signed [34:0] w_sm, w_sum;
    logic [31:0]        w_vel_new;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_d[c] = $signed({i_to[c][31], i_to[c]}) - $signed({i_from[c][31], i_from[c]});
        end
    end

    assign w_khi = r_k >> (64 - PULL_SHIFT);
    assign w_klo = r_k << PULL_SHIFT;

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            P_SQ: begin
                mul_start = 1'b1;
                mul_a     = {32'b0, r_a[r_ax][32:1]};
                mul_b     = {32'b0, r_a[r_ax][32:1]};
            end
            P_K1: begin
                mul_start = 1'b1;
                mul_a     = {54'b0, r_mass};
                mul_b     = {40'b0, i_dt};
            end
            P_K2: begin
                mul_start = 1'b1;
                mul_a     = r_k;
                mul_b     = MILLI_Q38;
            end
            P_H2: begin
                mul_start = 1'b1;
                mul_a     = {32'b0, r_h};
                mul_b     = {32'b0, r_h};
            end
            P_AX: begin
                mul_start = (r_a[r_ax] != '0) && !r_pcap;
                mul_a     = {31'b0, r_a[r_ax]};
                mul_b     = r_p;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_hi    = mul_p[127:64];
        div_lo    = mul_p[63:0];
        div_d     = {32'b0, r_h};
        unique case (r_state)
            P_PDIV: begin
                div_start = w_khi < r_h2;
                div_hi    = w_khi;
                div_lo    = w_klo;
                div_d     = r_h2;
            end
            P_AXMW: begin
                div_start = mul_done && (mul_p[127:64] < {32'b0, r_h});
            end
            default: begin
            end
        endcase
    end

    assign sq_start = (r_state == P_SQRT);

    always_comb begin
        unique case (r_state)
            P_AX:    w_m = (r_a[r_ax] == '0) ? '0 : PULL_CAP;
            P_AXMW:  w_m = PULL_CAP;
            default: w_m = {1'b0, div_q[63:32]};
        endcase
        w_sm      = r_neg[r_ax] ? -$signed({2'b00, w_m}) : $signed({2'b00, w_m});
        w_sum     = $signed({{3{r_vel[r_ax][31]}}, r_vel[r_ax]}) + w_sm;
        w_vel_new = sat32(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        for (int c = 0; c < 3; c++) begin
                            r_neg[c] <= w_d[c][32];
                            r_a[c]   <= w_d[c][32] ? 33'(-w_d[c]) : 33'(w_d[c]);
                        end
                        r_vel   <= i_vel;
                        r_mass  <= i_mass;
                        r_s     <= '0;
                        r_ax    <= '0;
                        r_state <= P_SQ;
                    end
                end
                P_SQ:  r_state <= P_SQW;
                P_SQW: begin
                    if (mul_done) begin
                        r_s <= r_s + mul_p[63:0];
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= P_SQRT;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= P_SQ;
                        end
                    end
                end
                P_SQRT:  r_state <= P_SQRTW;
                P_SQRTW: begin
                    if (sq_done) begin
                        r_h     <= sq_root;
                        r_state <= (sq_root == '0) ? P_FIN : P_K1;
                    end
                end
                P_K1:  r_state <= P_K1W;
                P_K1W: begin
                    if (mul_done) begin
                        r_k     <= mul_p[63:0];
                        r_state <= P_K2;
                    end
                end
                P_K2:  r_state <= P_K2W;
                P_K2W: begin
                    if (mul_done) begin
                        r_k     <= mul_p[63:0];
                        r_state <= P_H2;
                    end
                end
                P_H2:  r_state <= P_H2W;
                P_H2W: begin
                    if (mul_done) begin
                        r_h2    <= mul_p[63:0];
                        r_state <= P_PDIV;
                    end
                end
                P_PDIV: begin
                    r_pcap  <= !div_start;
                    r_state <= div_start ? P_PDIVW : P_AX;
                end
                P_PDIVW: begin
                    if (div_done) begin
                        r_p     <= div_q;
                        r_state <= P_AX;
                    end
                end
                P_AX: begin
                    if (mul_start) begin
                        r_state <= P_AXMW;
                    end else begin
                        r_vel[r_ax] <= w_vel_new;
                        r_ax        <= r_ax + 2'd1;
                        r_state     <= (r_ax == 2'd2) ? P_FIN : P_AX;
                    end
                end
                P_AXMW: begin
                    if (mul_done) begin
                        if (div_start) begin
                            r_state <= P_AXDW;
                        end else begin
                            r_vel[r_ax] <= w_vel_new;
                            r_ax        <= r_ax + 2'd1;
                            r_state     <= (r_ax == 2'd2) ? P_FIN : P_AX;
                        end
                    end
                end
                P_AXDW: begin
                    if (div_done) begin
                        r_vel[r_ax] <= w_vel_new;
                        r_ax        <= r_ax + 2'd1;
                        r_state     <= (r_ax == 2'd2) ? P_FIN : P_AX;
                    end
                end
                P_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= P_IDLE;
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    nbgs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    nbgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    (div_hi),
        .i_lo    (div_lo),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    nbgs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_s     (r_s),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_done = r_done;
    assign o_vel  = r_vel;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == P_IDLE)
        else $error("pull started while busy");

    a_pdiv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == P_PDIVW |-> r_h2 != '0)
        else $error("pull factor divide by zero");

endmodule

@@ src/nbody_gravity_star_step.sv @@
// nbody_gravity_star_step: top level; galaxy centre ring, item sequencer, drift and pixel.
// Depends on nbgs_pkg, nbgs_cell, nbgs_pull.
//
// Input channel (i_in_valid / o_in_stall) takes one word per item: a load, a star
// step or an advance of one centre. Output channel (o_out_valid / i_out_stall)
// returns one word per star step and per in-range advance.
// Configuration words (i_cfg_valid / o_cfg_ready) are taken in any cycle; ready is
// always high. Write them only while no item is in flight.
// A load is written into its slot directly and the block is ready again at once.
// A star step or advance rotates the five-slot centre ring once, one slot per
// visit. Each pull of a centre with nonzero mass runs the shared pull unit:
// three squares, a square root, three multiplies, one 128/64 division, then
// one multiply and one 128/64 division per axis, fewer where the pull is capped
// or a distance is zero. An advance runs two pulls per interacting pair. On
// top come the ring visits, drift and pixel mapping.
// A finished result sits in the output register; the next item is accepted
// while it waits. The input stalls while an item is in flight, and a new
// result waits in S_OUT while the old one is still held by i_out_stall.
// Reset clears all centres and loads the default configuration.
module nbody_gravity_star_step import nbgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_galaxy_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic [9:0]         i_mass_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_x,
    output logic signed [31:0] o_new_y,
    output logic signed [31:0] o_new_z,
    output logic signed [31:0] o_new_vx,
    output logic signed [31:0] o_new_vy,
    output logic signed [31:0] o_new_vz,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic               o_on_screen,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_PULL1, S_PULL2, S_ROT, S_DMUL, S_DADD,
        S_PMUL, S_PADD, S_STORE, S_OUT
    } t_state;

    t_state      r_state;
    logic [2:0]  r_num;
    logic [23:0] r_dt;
    logic [19:0] r_scale;
    logic [11:0] r_cx, r_cy;
    logic [12:0] r_clipr, r_clipb;

    t_op                r_op;
    logic [IDX_W-1:0]   r_idx, r_g;
    t_vec3              r_pos, r_vel, r_gvel;
    logic [9:0]         r_midx;
    logic               r_upd;
    logic [1:0]         r_ax;
    logic signed [56:0] r_prod;
    logic signed [26:0] r_px [2];

    logic               r_out_valid, r_on;
    t_vec3              r_out_pos, r_out_vel;
    logic [15:0]        r_sx, r_sy;

    t_gal             cell_q [MAX_CENTRES];
    t_gal             head, tail_in, wr_data;
    logic             wr_en, shift_en;
    logic [IDX_W-1:0] wr_idx;

    logic        pull_start, pull_done;
    t_vec3       pull_from, pull_to, pull_vin, pull_vel;
    logic [9:0]  pull_mass;

    logic [2:0]          w_n;
    logic                w_accept, w_gact, w_star_pull, w_adv_pull;
    logic signed [56:0]  w_drift_mul;
    logic signed [52:0]  w_pix_mul;
    logic [31:0]         w_drift_pos;
    logic signed [56:0]  w_pabs;
    logic signed [25:0]  w_q;
    logic signed [26:0]  w_px;

    function automatic logic [15:0] sat16(input logic signed [26:0] v);
        logic [15:0] r;
        if (v > 27'sd32767) begin
            r = 16'h7fff;
        end else if (v < -27'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign w_n        = (r_num > 3'(MAX_CENTRES)) ? 3'(MAX_CENTRES) : r_num;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign head   = cell_q[0];
    assign w_gact = r_g < w_n;
    assign w_star_pull = (r_op == OP_STAR) && w_gact && (head.mass != '0);
    assign w_adv_pull  = (r_op == OP_ADVANCE) && w_gact && (r_g > r_idx)
                         && (r_midx != '0) && (head.mass != '0);

    // ring: slot 0 is the head, the head re-enters at the tail
    assign shift_en     = (r_state == S_ROT);
    assign tail_in.pos  = head.pos;
    assign tail_in.vel  = r_upd ? r_gvel : head.vel;
    assign tail_in.mass = head.mass;

    always_comb begin
        if (r_state == S_IDLE) begin
            wr_en        = w_accept && (i_opcode == OP_LOAD)
                           && (i_galaxy_index < 3'(MAX_CENTRES));
            wr_idx       = i_galaxy_index;
            wr_data.pos  = {i_pos_z, i_pos_y, i_pos_x};
            wr_data.vel  = {i_vel_z, i_vel_y, i_vel_x};
            wr_data.mass = i_mass_in;
        end else begin
            wr_en        = (r_state == S_STORE) && (r_op == OP_ADVANCE);
            wr_idx       = r_idx;
            wr_data.pos  = r_pos;
            wr_data.vel  = r_vel;
            wr_data.mass = r_midx;
        end
    end

    for (genvar k = 0; k < MAX_CENTRES; k++) begin : g_ring
        t_gal nxt;
        if (k == MAX_CENTRES - 1) begin : g_tail
            assign nxt = tail_in;
        end else begin : g_mid
            assign nxt = cell_q[k + 1];
        end
        nbgs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift_en),
            .i_shift_data (nxt),
            .i_wr         (wr_en && (wr_idx == IDX_W'(k))),
            .i_wr_data    (wr_data),
            .o_data       (cell_q[k])
        );
    end

    always_comb begin
        if (r_state == S_PULL1) begin
            pull_start = pull_done && (r_op == OP_ADVANCE);
            pull_from  = head.pos;
            pull_to    = r_pos;
            pull_mass  = r_midx;
            pull_vin   = head.vel;
        end else begin
            pull_start = (r_state == S_HEAD) && (w_star_pull || w_adv_pull);
            pull_from  = r_pos;
            pull_to    = head.pos;
            pull_mass  = head.mass;
            pull_vin   = r_vel;
        end
    end

    nbgs_pull u_pull (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pull_start),
        .i_from  (pull_from),
        .i_to    (pull_to),
        .i_vel   (pull_vin),
        .i_mass  (pull_mass),
        .i_dt    (r_dt),
        .o_done  (pull_done),
        .o_vel   (pull_vel)
    );

    // drift: pos += floor(vel * dt / 2^24)
    assign w_drift_mul = $signed(r_vel[r_ax]) * $signed({1'b0, r_dt});
    assign w_drift_pos = sat32($signed({{3{r_pos[r_ax][31]}}, r_pos[r_ax]})
                         + $signed({{2{r_prod[56]}}, r_prod[56:DT_BITS]}));

    // pixel: truncate toward zero, then add the screen origin
    assign w_pix_mul = $signed(r_pos[r_ax]) * $signed({1'b0, r_scale});
    assign w_pabs    = r_prod[56] ? -r_prod : r_prod;
    assign w_q       = r_prod[56] ? -$signed({1'b0, w_pabs[56:PIX_SHIFT]})
                                  : $signed({1'b0, w_pabs[56:PIX_SHIFT]});
    assign w_px      = $signed({w_q[25], w_q})
                       + $signed({15'b0, (r_ax[0] ? r_cy : r_cx)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= 3'd2;
            r_dt        <= 24'd83886;
            r_scale     <= 20'd65536;
            r_cx        <= 12'd512;
            r_cy        <= 12'd384;
            r_clipr     <= 13'd1024;
            r_clipb     <= 13'd768;
            r_out_valid <= 1'b0;
            r_upd       <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NUM_GALAXIES: r_num   <= i_cfg_data[2:0];
                    CFG_TIME_STEP:    r_dt    <= i_cfg_data;
                    CFG_PIXEL_SCALE:  r_scale <= i_cfg_data[19:0];
                    CFG_CENTER_X:     r_cx    <= i_cfg_data[11:0];
                    CFG_CENTER_Y:     r_cy    <= i_cfg_data[11:0];
                    CFG_CLIP_RIGHT:   r_clipr <= i_cfg_data[12:0];
                    CFG_CLIP_BOTTOM:  r_clipb <= i_cfg_data[12:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= t_op'(i_opcode);
                        r_idx  <= i_galaxy_index;
                        r_pos  <= {i_pos_z, i_pos_y, i_pos_x};
                        r_vel  <= {i_vel_z, i_vel_y, i_vel_x};
                        r_g    <= '0;
                        r_upd  <= 1'b0;
                        r_midx <= '0;
                        if (i_opcode == OP_STAR
                            || (i_opcode == OP_ADVANCE && i_galaxy_index < w_n)) begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    if (r_op == OP_ADVANCE && r_g == r_idx) begin
                        r_pos  <= head.pos;
                        r_vel  <= head.vel;
                        r_midx <= head.mass;
                    end
                    r_state <= pull_start ? S_PULL1 : S_ROT;
                end
                S_PULL1: begin
                    if (pull_done) begin
                        r_vel   <= pull_vel;
                        r_state <= (r_op == OP_ADVANCE) ? S_PULL2 : S_ROT;
                    end
                end
                S_PULL2: begin
                    if (pull_done) begin
                        r_gvel  <= pull_vel;
                        r_upd   <= 1'b1;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_upd <= 1'b0;
                    r_g   <= r_g + IDX_W'(1);
                    if (r_g == IDX_W'(MAX_CENTRES - 1)) begin
                        r_ax    <= '0;
                        r_state <= S_DMUL;
                    end else begin
                        r_state <= S_HEAD;
                    end
                end
                S_DMUL: begin
                    r_prod  <= w_drift_mul;
                    r_state <= S_DADD;
                end
                S_DADD: begin
                    r_pos[r_ax] <= w_drift_pos;
                    if (r_ax == 2'd2) begin
                        r_ax    <= '0;
                        r_state <= S_PMUL;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_DMUL;
                    end
                end
                S_PMUL: begin
                    r_prod  <= {{4{w_pix_mul[52]}}, w_pix_mul};
                    r_state <= S_PADD;
                end
                S_PADD: begin
                    r_px[r_ax[0]] <= w_px;
                    if (r_ax == 2'd1) begin
                        r_state <= S_STORE;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_PMUL;
                    end
                end
                S_STORE: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_pos   <= r_pos;
                        r_out_vel   <= r_vel;
                        r_sx        <= sat16(r_px[0]);
                        r_sy        <= sat16(r_px[1]);
                        r_on        <= !r_px[0][26] && (r_px[0][25:0] < {13'b0, r_clipr})
                                       && !r_px[1][26] && (r_px[1][25:0] < {13'b0, r_clipb});
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_x     = r_out_pos[0];
    assign o_new_y     = r_out_pos[1];
    assign o_new_z     = r_out_pos[2];
    assign o_new_vx    = r_out_vel[0];
    assign o_new_vy    = r_out_vel[1];
    assign o_new_vz    = r_out_vel[2];
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_on_screen = r_on;

    a_star_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == OP_STAR) |=> o_in_stall)
        else $error("star step did not start");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HEAD |-> r_g < IDX_W'(MAX_CENTRES))
        else $error("ring visit past last slot");

    a_pull_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pull_done |-> (r_state == S_PULL1 || r_state == S_PULL2))
        else $error("pull finished outside a pull wait");

endmodule
